### sv/mbrc_pkg.sv
package mbrc_pkg;

  // Receive buffer limit on the total frame length in bytes.
  localparam int RxBufferSize = 256;
  localparam int LenW = 10;

  // Input operation codes carried in tuser.
  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpByte  = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  // Frame phase codes.
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhCount  = 2'd2;
  localparam logic [1:0] PhBody   = 2'd3;

  // Result kinds.
  localparam logic KindPdu    = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Status codes.
  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StTimeout  = 4'd1;
  localparam logic [3:0] StBadFunc  = 4'd2;
  localparam logic [3:0] StOversize = 4'd3;
  localparam logic [3:0] StCrc      = 4'd4;
  localparam logic [3:0] StUnit     = 4'd5;
  localparam logic [3:0] StExcOther = 4'd15;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [15:0] TickMax  = 16'hFFFF;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  // One input beat after the input register.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] unit_id;
    logic [7:0] exp_func;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] pdu_byte;
    logic [3:0] status;
  } result_t;

  // CRC-16/Modbus over one byte, reflected, eight shift steps unrolled.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // Exception code to status code.
  function automatic logic [3:0] exc_status(input logic [7:0] ex);
    logic [3:0] st;
    unique case (ex)
      8'h01:   st = 4'd6;
      8'h02:   st = 4'd7;
      8'h03:   st = 4'd8;
      8'h04:   st = 4'd9;
      8'h05:   st = 4'd10;
      8'h06:   st = 4'd11;
      8'h08:   st = 4'd12;
      8'h0A:   st = 4'd13;
      8'h0B:   st = 4'd14;
      default: st = StExcOther;
    endcase
    return st;
  endfunction

endpackage

### sv/modbus_rtu_response_checker.sv
// An accepted beat is held in the input register, and its result beat in the result register.
// Throughput: one input beat per cycle; the output register lets a new beat in while a
// result waits, and the input stage stalls only when a result beat cannot be placed.
// The byte-wise CRC update and frame checks sit between the input and result registers.
// Reset (rst_n low, synchronous): no frame armed, both stages empty, timeout back to 1000.
module modbus_rtu_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], unit_id[15:8], expected_function[23:16]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pdu_byte[7:0], status[11:8], zero[15:12]
  output logic [0:0]  out_tuser,  // kind[0]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // timeout_ticks[15:0]
);
  import mbrc_pkg::*;

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        s1_adv;
  result_t     res;
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_status_r;
  logic [15:0] timeout_r;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // The input stage moves on unless its result has nowhere to go.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready || !res.valid);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= '{op: in_tuser, data_byte: in_tdata[7:0],
                     unit_id: in_tdata[15:8], exp_func: in_tdata[23:16]};
    end
  end

  mbrc_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_adv),
    .item          (s1_item_r),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_kind_r   <= res.kind;
      out_byte_r   <= res.pdu_byte;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_status_r, out_byte_r};
  assign out_tuser  = out_kind_r;

endmodule

### sv/mbrc_frame.sv
module mbrc_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  mbrc_pkg::item_t   item,
  input  logic [15:0]       timeout_ticks,
  output mbrc_pkg::result_t res
);
  import mbrc_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  arm_unit_r, arm_unit_nxt;
  logic [7:0]  arm_func_r, arm_func_nxt;
  logic [7:0]  rep_unit_r, rep_unit_nxt;
  logic [7:0]  rep_func_r, rep_func_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [15:0] tick_r, tick_nxt;

  logic [15:0] crc_b;
  logic [15:0] tick_inc;
  logic [LenW-1:0] pos_p2;
  logic [LenW-1:0] count_len;
  logic [15:0] crc_rx;
  logic [7:0]  b;

  assign b        = item.data_byte;
  assign crc_b    = crc_feed(crc_r, b);
  assign tick_inc = (tick_r != TickMax) ? tick_r + 16'd1 : tick_r;
  assign pos_p2   = {1'b0, pos_r} + LenW'(2);
  assign count_len = LenW'(5) + {2'b00, b};
  assign crc_rx   = {b, crc_lo_r};

  // Next state and result for the registered beat.
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    arm_unit_nxt = arm_unit_r;
    arm_func_nxt = arm_func_r;
    rep_unit_nxt = rep_unit_r;
    rep_func_nxt = rep_func_r;
    exc_nxt      = exc_r;
    tick_nxt     = tick_r;
    res          = '0;

    if (item.op == OpStart) begin
      // Rearm: drop any running frame.
      phase_nxt    = PhHeader;
      pos_nxt      = '0;
      len_nxt      = '0;
      crc_nxt      = CrcInit;
      crc_lo_nxt   = '0;
      rep_unit_nxt = '0;
      rep_func_nxt = '0;
      exc_nxt      = '0;
      tick_nxt     = '0;
      arm_unit_nxt = item.unit_id;
      arm_func_nxt = item.exp_func;
    end else if (phase_r != PhIdle && item.op == OpTick) begin
      tick_nxt = tick_inc;
      if (tick_inc >= timeout_ticks) begin
        res       = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00, status: StTimeout};
        phase_nxt = PhIdle;
      end
    end else if (phase_r != PhIdle && item.op == OpByte) begin
      pos_nxt = pos_r + 9'd1;
      unique case (phase_r)
        PhHeader: begin
          crc_nxt = crc_b;
          if (pos_r == '0) begin
            rep_unit_nxt = b;
          end else begin
            rep_func_nxt = b;
            tick_nxt     = '0;
            res = '{valid: 1'b1, kind: KindPdu, pdu_byte: b, status: StOk};
            if (b[7]) begin
              len_nxt   = 9'd5;
              phase_nxt = PhBody;
              if (LenW'(5) > LenW'(RxBufferSize)) begin
                res       = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00,
                              status: StOversize};
                phase_nxt = PhIdle;
              end
            end else begin
              case (b) inside
                8'h01, 8'h02, 8'h03, 8'h04: begin
                  phase_nxt = PhCount;
                end
                8'h05, 8'h06, 8'h0F, 8'h10: begin
                  len_nxt   = 9'd8;
                  phase_nxt = PhBody;
                  if (LenW'(8) > LenW'(RxBufferSize)) begin
                    res       = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00,
                                  status: StOversize};
                    phase_nxt = PhIdle;
                  end
                end
                default: begin
                  res       = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00,
                                status: StBadFunc};
                  phase_nxt = PhIdle;
                end
              endcase
            end
          end
        end
        PhCount: begin
          crc_nxt  = crc_b;
          len_nxt  = count_len[8:0];
          tick_nxt = '0;
          if (count_len > LenW'(RxBufferSize)) begin
            res       = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00, status: StOversize};
            phase_nxt = PhIdle;
          end else begin
            res       = '{valid: 1'b1, kind: KindPdu, pdu_byte: b, status: StOk};
            phase_nxt = PhBody;
          end
        end
        PhBody: begin
          if (pos_p2 < {1'b0, len_r}) begin
            // Payload byte: into the CRC and passed on.
            crc_nxt = crc_b;
            if (pos_r == 9'd2 && rep_func_r[7]) exc_nxt = b;
            res = '{valid: 1'b1, kind: KindPdu, pdu_byte: b, status: StOk};
          end else if (pos_p2 == {1'b0, len_r}) begin
            crc_lo_nxt = b;
          end else begin
            // Last CRC byte: final checks in priority order.
            phase_nxt = PhIdle;
            res = '{valid: 1'b1, kind: KindStatus, pdu_byte: 8'h00, status: StOk};
            if (crc_rx != crc_r)               res.status = StCrc;
            else if (rep_unit_r != arm_unit_r) res.status = StUnit;
            else if (rep_func_r[7])            res.status = exc_status(exc_r);
            else if (rep_func_r != arm_func_r) res.status = StBadFunc;
          end
        end
        default: begin
          phase_nxt = PhIdle;
        end
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PhIdle;
      pos_r      <= '0;
      len_r      <= '0;
      crc_r      <= CrcInit;
      crc_lo_r   <= '0;
      arm_unit_r <= '0;
      arm_func_r <= '0;
      rep_unit_r <= '0;
      rep_func_r <= '0;
      exc_r      <= '0;
      tick_r     <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      arm_unit_r <= arm_unit_nxt;
      arm_func_r <= arm_func_nxt;
      rep_unit_r <= rep_unit_nxt;
      rep_func_r <= rep_func_nxt;
      exc_r      <= exc_nxt;
      tick_r     <= tick_nxt;
    end
  end

endmodule

### sv/mbrc_checker.sv
module mbrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import mbrc_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A passed PDU beat carries a zero status.
  a_pdu_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KindPdu |-> out_tdata[11:8] == StOk)
    else $error("PDU beat with nonzero status");

  // A status beat carries a zero data byte and no padding bits.
  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KindStatus |->
      out_tdata[7:0] == 8'h00 && out_tdata[15:12] == 4'h0)
    else $error("status beat with nonzero data byte");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind modbus_rtu_response_checker mbrc_checker u_mbrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
